/* sv/bht_pkg.sv */
`default_nettype none
package bht_pkg;

    localparam int WIN_DEPTH = 10;
    localparam int W_IDX     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
    localparam int W_CNT     = $clog2(WIN_DEPTH + 1);

    localparam int RR_W   = 12;
    localparam int HR_W   = 16;
    localparam int REF_W  = 20;
    localparam int S1_W   = RR_W + W_CNT;
    localparam int S2_W   = 2 * RR_W + W_CNT;
    localparam int SHR_W  = HR_W + W_CNT;
    localparam int D_W    = 2 * RR_W + W_CNT;
    localparam int VAR_W  = 2 * RR_W + 2 * W_CNT;
    localparam int NUM_W  = VAR_W + 8;
    localparam int DEN_W  = 12;
    localparam int ROOT_W = NUM_W / 2;
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int SCNT_W = $clog2(ROOT_W + 1);

    localparam logic [23:0] HR_SCALE = 24'd15360000;
    localparam logic [14:0] RR_SCALE = 15'd25600;
    localparam logic [6:0]  PCT_FULL = 7'd100;

    // Division by five as a multiply by ceil(2^26 / 5) and a shift; exact for
    // dividends below 2^26, and the reference update never exceeds 2^23.
    localparam logic [23:0] DIV5_RECIP = 24'd13421773;
    localparam int          DIV5_SHIFT = 26;

    localparam logic [1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_MAX_INTERVAL = 2'd1;
    localparam logic [1:0] CFG_OUTLIER_PCT  = 2'd2;

    localparam logic [2:0] ST_NO_BEAT  = 3'd0;
    localparam logic [2:0] ST_FIRST    = 3'd1;
    localparam logic [2:0] ST_RESTART  = 3'd2;
    localparam logic [2:0] ST_SHORT    = 3'd3;
    localparam logic [2:0] ST_OUTLIER  = 3'd4;
    localparam logic [2:0] ST_ACCEPTED = 3'd5;
    localparam logic [2:0] ST_UPDATED  = 3'd6;

    typedef struct packed {
        logic        beat;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [15:0] hr_mean_q8;
        logic [14:0] rr_std_q4;
        logic [14:0] rmssd_q4;
        logic [2:0]  status;
    } t_out;

    typedef struct packed {
        logic [RR_W-1:0] rr;
        logic [HR_W-1:0] hr;
    } t_win_entry;

    typedef struct packed {
        logic             go;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             go;
        logic [NUM_W-1:0] val;
    } t_sqrt_req;

    typedef enum logic [4:0] {
        S_IDLE, S_EVAL, S_CHK, S_HRDIV, S_WR, S_RD, S_ACC,
        S_MEAN, S_MEANW, S_VAR, S_VARW, S_SQ1, S_RMW, S_SQ2, S_OUT
    } t_state;

endpackage
`default_nettype wire

/* sv/bht_win_ram.sv */
`default_nettype none
module bht_win_ram (
    input  wire                        i_clk,
    input  wire                        i_we,
    input  wire [bht_pkg::W_IDX-1:0]   i_waddr,
    input  bht_pkg::t_win_entry        i_wdata,
    input  wire [bht_pkg::W_IDX-1:0]   i_raddr,
    output bht_pkg::t_win_entry        o_rdata
);
    import bht_pkg::*;

    t_win_entry r_mem [WIN_DEPTH];
    t_win_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* sv/bht_div.sv */
`default_nettype none
module bht_div (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  bht_pkg::t_div_req          i_req,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [bht_pkg::NUM_W-1:0]  o_quot
);
    import bht_pkg::*;

    logic [NUM_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DEN_W:0]    trial;
    logic              ge;

    // Restoring division, one quotient bit per cycle.
    assign trial = {r_rem, r_q[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(NUM_W);
                r_q    <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_q   <= {r_q[NUM_W-2:0], ge};
                r_rem <= ge ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

/* sv/bht_sqrt.sv */
`default_nettype none
module bht_sqrt (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  bht_pkg::t_sqrt_req          i_req,
    output logic                        o_done,
    output logic [bht_pkg::ROOT_W-1:0]  o_root
);
    import bht_pkg::*;

    logic [NUM_W-1:0]  r_v;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W:0]   r_rem;
    logic [SCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [ROOT_W+2:0] rem_t;
    logic [ROOT_W+2:0] trial;
    logic              ge;

    // Digit-by-digit root, two radicand bits per cycle.
    assign rem_t = {r_rem, r_v[NUM_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign ge    = rem_t >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= SCNT_W'(ROOT_W);
                r_v    <= i_req.val;
                r_root <= '0;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_v    <= {r_v[NUM_W-3:0], 2'b00};
                r_root <= {r_root[ROOT_W-2:0], ge};
                r_rem  <= ge ? (ROOT_W+1)'(rem_t - trial) : rem_t[ROOT_W:0];
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == SCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule
`default_nettype wire

/* sv/beat_interval_hrv_tracker.sv */
// Channel  | Direction | Handshake                | Payload
// input    | in        | i_in_valid / o_in_stall  | i_in  (beat, now_ms)
// result   | out       | o_out_valid / i_out_stall| o_out (hr, std, rmssd, status)
// config   | in        | i_cfg_we                 | i_cfg_idx, i_cfg_data
// A request without a beat, with a short beat or with a gap restart goes from evaluation
// to the output state, and an outlier passes the check state as well. An accepted beat
// that leaves under two entries takes one divider pass; one that updates the features
// reads every window entry and takes four passes of the shared 40-step divider and two of the root.
// Reset is synchronous; no clearing pass is needed, only written entries are read.
// A stalled result waits in the output register while the next request is taken.
`default_nettype none
module beat_interval_hrv_tracker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  bht_pkg::t_in i_in,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output bht_pkg::t_out o_out,
    input  wire          i_cfg_we,
    input  wire [1:0]    i_cfg_idx,
    input  wire [11:0]   i_cfg_data
);
    import bht_pkg::*;

    t_state r_state, n_state;

    logic [11:0] r_min, r_max;
    logic [6:0]  r_pct;

    logic             r_beat, n_beat;
    logic [31:0]      r_now, n_now;
    logic [31:0]      r_last, n_last;
    logic             r_have, n_have;
    logic [REF_W-1:0] r_ref, n_ref;
    logic             r_upd_ref, n_upd_ref;
    logic [RR_W-1:0]  r_rr, n_rr;
    logic [HR_W-1:0]  r_hr, n_hr;
    logic [27:0]      r_scaled, n_scaled, r_lo, n_lo, r_hi, n_hi;
    logic [W_IDX-1:0] r_ws, n_ws, r_idx, n_idx;
    logic [W_CNT-1:0] r_fill, n_fill, r_k, n_k;
    logic [S1_W-1:0]  r_s1, n_s1;
    logic [S2_W-1:0]  r_s2, n_s2;
    logic [SHR_W-1:0] r_shr, n_shr;
    logic [D_W-1:0]   r_d, n_d;
    logic [RR_W-1:0]  r_prev, n_prev;
    logic [VAR_W-1:0] r_va, n_va, r_vb, n_vb;
    logic [15:0]      r_hr_h, n_hr_h;
    logic [14:0]      r_std_h, n_std_h, r_rms_h, n_rms_h;
    logic [2:0]       r_status, n_status;
    logic             r_out_valid, n_out_valid;
    t_out             r_out, n_out;

    t_div_req         div_req;
    t_sqrt_req        sq_req;
    logic             div_busy, div_done, sq_done;
    logic [NUM_W-1:0] div_q;
    logic [ROOT_W-1:0] sq_root;

    logic             mem_we;
    t_win_entry       mem_wdata, mem_rdata;

    logic [31:0]      rr32;
    logic [6:0]       lo_pct;
    logic [7:0]       hi_pct;
    logic [W_CNT:0]   start_t;
    logic [W_CNT-1:0] fill_nx;
    logic [W_IDX-1:0] ws_nx;
    logic [RR_W-1:0]  xd;
    logic [RR_W-1:0]  diff;
    logic [22:0]      ref_sum;
    logic [46:0]      ref_prod;

    bht_win_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_ws),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    bht_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    bht_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign rr32   = r_now - r_last;
    assign lo_pct = (r_pct < PCT_FULL) ? PCT_FULL - r_pct : 7'd0;
    assign hi_pct = {1'b0, PCT_FULL} + {1'b0, r_pct};
    assign xd     = mem_rdata.rr;
    assign diff   = (xd > r_prev) ? xd - r_prev : r_prev - xd;
    assign ws_nx  = (r_ws == W_IDX'(WIN_DEPTH - 1)) ? '0 : r_ws + 1'b1;
    assign fill_nx = (r_fill < W_CNT'(WIN_DEPTH)) ? r_fill + 1'b1 : r_fill;
    // Oldest entry: write slot minus fill, modulo the window depth.
    assign start_t = {1'b0, W_CNT'(ws_nx)} + (W_CNT+1)'(WIN_DEPTH) - {1'b0, fill_nx};

    // Reference update (4*ref + 256*rr + 2) / 5, floored.
    assign ref_sum  = {1'b0, r_ref, 2'b00} + 23'({r_rr, 8'd0}) + 23'd2;
    assign ref_prod = 47'(ref_sum) * 47'(DIV5_RECIP);

    assign mem_we    = (r_state == S_WR);
    assign mem_wdata = '{rr: r_rr, hr: r_hr};

    always_comb begin
        n_state = r_state;
        n_beat = r_beat; n_now = r_now; n_last = r_last; n_have = r_have;
        n_ref = r_ref; n_upd_ref = r_upd_ref; n_rr = r_rr; n_hr = r_hr;
        n_scaled = r_scaled; n_lo = r_lo; n_hi = r_hi;
        n_ws = r_ws; n_idx = r_idx; n_fill = r_fill; n_k = r_k;
        n_s1 = r_s1; n_s2 = r_s2; n_shr = r_shr; n_d = r_d; n_prev = r_prev;
        n_va = r_va; n_vb = r_vb;
        n_hr_h = r_hr_h; n_std_h = r_std_h; n_rms_h = r_rms_h;
        n_status = r_status; n_out_valid = r_out_valid; n_out = r_out;
        div_req = '{go: 1'b0, num: '0, den: '0};
        sq_req  = '{go: 1'b0, val: '0};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_beat  = i_in.beat;
                    n_now   = i_in.now_ms;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_OUT;
                if (!r_beat) begin
                    n_status = ST_NO_BEAT;
                end else if (!r_have) begin
                    n_have   = 1'b1;
                    n_last   = r_now;
                    n_status = ST_FIRST;
                end else if (rr32 > {20'd0, r_max}) begin
                    n_last   = r_now;
                    n_ref    = '0;
                    n_status = ST_RESTART;
                end else if (rr32 == 32'd0 || rr32 < {20'd0, r_min}) begin
                    n_status = ST_SHORT;
                end else begin
                    n_rr     = rr32[RR_W-1:0];
                    n_scaled = 28'(rr32[RR_W-1:0]) * 28'(RR_SCALE);
                    n_lo     = 28'(r_ref) * 28'(lo_pct);
                    n_hi     = 28'(r_ref) * 28'(hi_pct);
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (r_ref != '0 && (r_scaled < r_lo || r_scaled > r_hi)) begin
                    n_status = ST_OUTLIER;
                    n_state  = S_OUT;
                end else begin
                    n_last    = r_now;
                    n_upd_ref = (r_ref != '0);
                    div_req   = '{go: 1'b1,
                                  num: NUM_W'(HR_SCALE) + NUM_W'(r_rr >> 1),
                                  den: r_rr};
                    n_state   = S_HRDIV;
                end
            end
            S_HRDIV: begin
                if (div_done) begin
                    n_hr    = (|div_q[NUM_W-1:HR_W]) ? '1 : div_q[HR_W-1:0];
                    n_ref   = r_upd_ref ? ref_prod[DIV5_SHIFT +: REF_W] : {r_rr, 8'd0};
                    n_state = S_WR;
                end
            end
            S_WR: begin
                n_ws   = ws_nx;
                n_fill = fill_nx;
                if (fill_nx >= W_CNT'(2)) begin
                    n_idx   = (start_t >= (W_CNT+1)'(WIN_DEPTH))
                              ? W_IDX'(start_t - (W_CNT+1)'(WIN_DEPTH))
                              : W_IDX'(start_t);
                    n_k     = '0;
                    n_s1    = '0;
                    n_s2    = '0;
                    n_shr   = '0;
                    n_d     = '0;
                    n_state = S_RD;
                end else begin
                    n_status = ST_ACCEPTED;
                    n_state  = S_OUT;
                end
            end
            S_RD: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_s1   = r_s1 + S1_W'(xd);
                n_s2   = r_s2 + S2_W'(24'(xd) * 24'(xd));
                n_shr  = r_shr + SHR_W'(mem_rdata.hr);
                if (r_k != '0) begin
                    n_d = r_d + D_W'(24'(diff) * 24'(diff));
                end
                n_prev = xd;
                n_k    = r_k + 1'b1;
                n_idx  = (r_idx == W_IDX'(WIN_DEPTH - 1)) ? '0 : r_idx + 1'b1;
                n_state = (r_k == r_fill - 1'b1) ? S_MEAN : S_RD;
            end
            S_MEAN: begin
                div_req = '{go: 1'b1,
                            num: NUM_W'(r_shr) + NUM_W'(r_fill >> 1),
                            den: DEN_W'(r_fill)};
                n_state = S_MEANW;
            end
            S_MEANW: begin
                if (div_done) begin
                    n_hr_h  = (|div_q[NUM_W-1:16]) ? 16'hFFFF : div_q[15:0];
                    n_va    = VAR_W'(r_fill) * VAR_W'(r_s2);
                    n_vb    = VAR_W'(r_s1) * VAR_W'(r_s1);
                    n_state = S_VAR;
                end
            end
            S_VAR: begin
                div_req = '{go: 1'b1,
                            num: {r_va - r_vb, 8'd0},
                            den: DEN_W'(r_fill) * DEN_W'(r_fill)};
                n_state = S_VARW;
            end
            S_VARW: begin
                if (div_done) begin
                    sq_req  = '{go: 1'b1, val: div_q};
                    n_state = S_SQ1;
                end
            end
            S_SQ1: begin
                if (sq_done) begin
                    n_std_h = (|sq_root[ROOT_W-1:15]) ? 15'h7FFF : sq_root[14:0];
                    div_req = '{go: 1'b1,
                                num: NUM_W'({r_d, 8'd0}),
                                den: DEN_W'(r_fill - 1'b1)};
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                if (div_done) begin
                    sq_req  = '{go: 1'b1, val: div_q};
                    n_state = S_SQ2;
                end
            end
            S_SQ2: begin
                if (sq_done) begin
                    n_rms_h  = (|sq_root[ROOT_W-1:15]) ? 15'h7FFF : sq_root[14:0];
                    n_status = ST_UPDATED;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = '{hr_mean_q8: r_hr_h, rr_std_q4: r_std_h,
                                    rmssd_q4: r_rms_h, status: r_status};
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min       <= 12'd300;
            r_max       <= 12'd2000;
            r_pct       <= 7'd30;
            r_last      <= '0;
            r_have      <= 1'b0;
            r_ref       <= '0;
            r_ws        <= '0;
            r_fill      <= '0;
            r_hr_h      <= '0;
            r_std_h     <= '0;
            r_rms_h     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_have      <= n_have;
            r_ref       <= n_ref;
            r_ws        <= n_ws;
            r_fill      <= n_fill;
            r_hr_h      <= n_hr_h;
            r_std_h     <= n_std_h;
            r_rms_h     <= n_rms_h;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MIN_INTERVAL: r_min <= i_cfg_data;
                    CFG_MAX_INTERVAL: r_max <= i_cfg_data;
                    CFG_OUTLIER_PCT:  r_pct <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_beat    <= n_beat;
        r_now     <= n_now;
        r_upd_ref <= n_upd_ref;
        r_rr      <= n_rr;
        r_hr      <= n_hr;
        r_scaled  <= n_scaled;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_idx     <= n_idx;
        r_k       <= n_k;
        r_s1      <= n_s1;
        r_s2      <= n_s2;
        r_shr     <= n_shr;
        r_d       <= n_d;
        r_prev    <= n_prev;
        r_va      <= n_va;
        r_vb      <= n_vb;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= W_CNT'(WIN_DEPTH))
        else $error("window fill count beyond depth");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ws <= W_IDX'(WIN_DEPTH - 1))
        else $error("write slot out of range");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.go |-> !div_busy)
        else $error("divider started while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && i_out_stall) |=> r_state == S_OUT)
        else $error("pending result overwritten");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_state == S_EVAL)
        else $error("accepted request not evaluated");

endmodule
`default_nettype wire

/* verif/beat_interval_hrv_tracker_tb.sv */
`timescale 1ns / 1ps
module beat_interval_hrv_tracker_tb;
    import bht_pkg::*;

    localparam int DEPTH      = WIN_DEPTH;
    localparam int HANG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in         i_in = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_MIN_INTERVAL;
    logic [11:0] i_cfg_data = '0;

    beat_interval_hrv_tracker dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state.
    logic [11:0] min_ms, max_ms;
    logic [6:0]  pct;
    logic [31:0] last_time;
    logic        have_last;
    logic [31:0] rhythm_ref;
    logic [11:0] rr_win [DEPTH];
    logic [15:0] hr_win [DEPTH];
    int unsigned slot, fill;
    logic [15:0] hold_hr;
    logic [14:0] hold_std, hold_rmssd;

    t_in  pending_requests [$];
    t_out expected_results [$];
    int   mismatches = 0;
    int   hang_count = 0;
    bit   quiet_idle = 0;
    bit   sender_hold = 0;
    bit   in_fired = 0;
    logic [31:0] clock_ms;

    function automatic longint unsigned isqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic void refresh_features();
        longint unsigned n, s1, s2, shr, d, prv, x, df, v, q;
        int unsigned first, idx;
        n = fill; s1 = 0; s2 = 0; shr = 0; d = 0; prv = 0;
        first = (slot + DEPTH - fill) % DEPTH;
        for (int k = 0; k < fill; k++) begin
            idx = (first + k) % DEPTH;
            x = rr_win[idx];
            s1 += x; s2 += x * x; shr += hr_win[idx];
            if (k > 0) begin
                df = (x > prv) ? x - prv : prv - x;
                d += df * df;
            end
            prv = x;
        end
        q = (shr + n / 2) / n;
        hold_hr = (q > 65535) ? 16'hFFFF : q[15:0];
        v = n * s2 - s1 * s1;
        q = isqrt((256 * v) / (n * n));
        hold_std = (q > 32767) ? 15'h7FFF : q[14:0];
        q = isqrt((256 * d) / (n - 1));
        hold_rmssd = (q > 32767) ? 15'h7FFF : q[14:0];
    endfunction

    function automatic t_out track_beat(t_in req);
        t_out r;
        logic [31:0] rr;
        longint unsigned scaled, rf, lo, hi, hr;
        r.status = ST_NO_BEAT;
        if (req.beat) begin
            if (!have_last) begin
                have_last = 1;
                last_time = req.now_ms;
                r.status = ST_FIRST;
            end else begin
                rr = req.now_ms - last_time;
                if (rr > max_ms) begin
                    last_time = req.now_ms;
                    rhythm_ref = 0;
                    r.status = ST_RESTART;
                end else if (rr == 0 || rr < min_ms) begin
                    r.status = ST_SHORT;
                end else begin
                    scaled = rr * 25600;
                    rf = rhythm_ref;
                    lo = (pct < 100) ? 100 - pct : 0;
                    hi = 100 + pct;
                    if (rf != 0 && (scaled < rf * lo || scaled > rf * hi)) begin
                        r.status = ST_OUTLIER;
                    end else begin
                        last_time = req.now_ms;
                        if (rf == 0) rhythm_ref = rr << 8;
                        else rhythm_ref = (4 * rf + (rr << 8) + 2) / 5;
                        hr = (15360000 + rr / 2) / rr;
                        if (hr > 65535) hr = 65535;
                        rr_win[slot] = rr[11:0];
                        hr_win[slot] = hr[15:0];
                        slot = (slot + 1) % DEPTH;
                        if (fill < DEPTH) fill++;
                        if (fill >= 2) begin
                            refresh_features();
                            r.status = ST_UPDATED;
                        end else begin
                            r.status = ST_ACCEPTED;
                        end
                    end
                end
            end
        end
        r.hr_mean_q8 = hold_hr;
        r.rr_std_q4 = hold_std;
        r.rmssd_q4 = hold_rmssd;
        return r;
    endfunction

    function automatic bit idle_now();
        return !quiet_idle && ($urandom_range(99) < 13);
    endfunction

    // Driver: the valid stays up until the request has been taken.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !in_fired) begin
                // Hold the stalled request.
            end else if (pending_requests.size() != 0 && !sender_hold
                         && !idle_now()) begin
                i_in <= pending_requests.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
            i_out_stall <= idle_now();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            hang_count++;
            in_fired <= i_in_valid && !o_in_stall;
            if (i_in_valid && !o_in_stall) begin
                expected_results.push_back(track_beat(i_in));
                hang_count = 0;
            end
            if (o_out_valid && !i_out_stall) begin
                hang_count = 0;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", o_out);
                end else begin
                    t_out e;
                    e = expected_results.pop_front();
                    if (e !== o_out) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected hr %0d std %0d rmssd %0d st %0d,",
                                      " got hr %0d std %0d rmssd %0d st %0d"},
                                     e.hr_mean_q8, e.rr_std_q4, e.rmssd_q4, e.status,
                                     o_out.hr_mean_q8, o_out.rr_std_q4, o_out.rmssd_q4,
                                     o_out.status);
                    end
                end
            end
            if (hang_count >= HANG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic drain();
        while (pending_requests.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
        while (i_in_valid || expected_results.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [11:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MIN_INTERVAL: min_ms = val;
            CFG_MAX_INTERVAL: max_ms = val;
            CFG_OUTLIER_PCT:  pct = val[6:0];
            default: ;
        endcase
    endtask

    task automatic add_req(bit b, logic [31:0] t);
        t_in q;
        q.beat = b; q.now_ms = t;
        pending_requests.push_back(q);
    endtask

    // A run of beats around a base interval with jitter and the odd noise request.
    task automatic add_rhythm(int count, int base_ms, int jitter);
        int gap;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(19))
                0: add_req(0, $urandom);
                1: add_req(1, clock_ms + $urandom_range(60));
                2: add_req(1, clock_ms + base_ms * 3);
                default: begin
                    gap = base_ms + int'($urandom_range(2 * jitter)) - jitter;
                    if (gap < 1) gap = 1;
                    clock_ms += gap;
                    add_req(1, clock_ms);
                end
            endcase
        end
    endtask

    initial begin
        min_ms = 300; max_ms = 2000; pct = 30;
        last_time = 0; have_last = 0; rhythm_ref = 0;
        slot = 0; fill = 0; hold_hr = 0; hold_std = 0; hold_rmssd = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: no beat, first beat, short, zero interval, restart, wrap-around,
        // outlier above, acceptance and feature updates.
        add_req(0, 32'hFFFF_FFFF);
        add_req(0, 32'h0);
        add_req(1, 32'hFFFF_FE00);
        add_req(1, 32'hFFFF_FE00);
        add_req(1, 32'hFFFF_FF00);
        add_req(1, 32'h0000_0200);
        add_req(1, 32'h0000_0500);
        add_req(1, 32'h0000_0A00);
        add_req(1, 32'h0000_0D20);
        add_req(1, 32'h0000_1020);
        add_req(1, 32'h0000_1120);
        add_req(1, 32'h0000_1420);
        add_req(1, 32'h0000_1600);
        add_req(1, 32'h0000_1900);
        add_req(1, 32'h0001_0000);
        drain();

        // Extremes: tiny limits, min above max, zero and maximal percentages.
        write_reg(CFG_MIN_INTERVAL, 12'd1);
        write_reg(CFG_MAX_INTERVAL, 12'hFFF);
        write_reg(CFG_OUTLIER_PCT, 12'd127);
        clock_ms = 32'h0010_0000;
        add_req(1, clock_ms);
        add_rhythm(25, 1, 1);
        add_rhythm(25, 4000, 95);
        add_rhythm(20, 20, 19);
        drain();

        write_reg(CFG_MIN_INTERVAL, 12'hFFF);
        write_reg(CFG_MAX_INTERVAL, 12'd1);
        write_reg(CFG_OUTLIER_PCT, 12'd0);
        add_rhythm(30, 800, 800);
        drain();

        write_reg(CFG_MIN_INTERVAL, 12'd0);
        write_reg(CFG_MAX_INTERVAL, 12'd2500);
        write_reg(CFG_OUTLIER_PCT, 12'd100);
        add_rhythm(60, 700, 400);
        drain();

        // Random phases, mostly plausible rhythms.
        for (int ph = 0; ph < 12; ph++) begin
            write_reg(CFG_MIN_INTERVAL, $urandom_range(150, 600));
            write_reg(CFG_MAX_INTERVAL, $urandom_range(1200, 4095));
            write_reg(CFG_OUTLIER_PCT, $urandom_range(5, 100));
            quiet_idle = (ph == 5);
            if ($urandom_range(3) == 0) clock_ms = $urandom;
            add_rhythm(127, $urandom_range(400, 1200), $urandom_range(5, 200));
            if (ph == 7) begin
                // Pause the sender part-way through until every result is back.
                while (pending_requests.size() > 60) @(posedge i_clk);
                sender_hold = 1;
                while (expected_results.size() != 0 || i_in_valid) @(posedge i_clk);
                sender_hold = 0;
            end
            drain();
        end
        quiet_idle = 0;
        if (mismatches == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
